>>> rtl/vga_pkg.sv
// Shared types, codes and constant tables of the voice gate with AGC.
package vga_pkg;

    typedef enum logic [1:0] {
        FUNC_SAMPLE = 2'd0,
        FUNC_TICK   = 2'd1,
        FUNC_START  = 2'd2,
        FUNC_STOP   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        GATE_STOPPED = 2'd0,
        GATE_WAITING = 2'd1,
        GATE_RUNNING = 2'd2
    } t_gate_mode;

    localparam logic [2:0] CFG_FRAME_LENGTH     = 3'd0;
    localparam logic [2:0] CFG_SPEECH_THRESHOLD = 3'd1;
    localparam logic [2:0] CFG_HOLD_TICKS       = 3'd2;
    localparam logic [2:0] CFG_SOFT_AGC_ON      = 3'd3;
    localparam logic [2:0] CFG_HARD_AGC_ON      = 3'd4;
    localparam logic [2:0] CFG_AGC_TARGET       = 3'd5;
    localparam logic [2:0] CFG_AGC_RATE         = 3'd6;

    localparam int CFG_LEN_W = 11;
    localparam logic [CFG_LEN_W-1:0] FRAME_LENGTH_RST = 11'd320;
    localparam logic [15:0] UNITY_GAIN = 16'd4096;
    localparam logic [16:0] FULL_SCALE = 17'd32768;
    localparam logic signed [7:0] DB_SILENCE = -8'sd96;

    // db step n: largest peak whose level is at or below -n dB
    localparam int DB_STEPS = 90;
    localparam logic [15:0] DB_THR [0:DB_STEPS] = '{
        16'd32768, 16'd29204, 16'd26028, 16'd23197, 16'd20675, 16'd18426,
        16'd16422, 16'd14636, 16'd13045, 16'd11626, 16'd10362, 16'd9235,
        16'd8230,  16'd7335,  16'd6538,  16'd5827,  16'd5193,  16'd4628,
        16'd4125,  16'd3676,
        16'd3276,  16'd2920,  16'd2602,  16'd2319,  16'd2067,  16'd1842,
        16'd1642,  16'd1463,  16'd1304,  16'd1162,  16'd1036,  16'd923,
        16'd823,   16'd733,   16'd653,   16'd582,   16'd519,   16'd462,
        16'd412,   16'd367,
        16'd327,   16'd292,   16'd260,   16'd231,   16'd206,   16'd184,
        16'd164,   16'd146,   16'd130,   16'd116,   16'd103,   16'd92,
        16'd82,    16'd73,    16'd65,    16'd58,    16'd51,    16'd46,
        16'd41,    16'd36,
        16'd32,    16'd29,    16'd26,    16'd23,    16'd20,    16'd18,
        16'd16,    16'd14,    16'd13,    16'd11,    16'd10,    16'd9,
        16'd8,     16'd7,     16'd6,     16'd5,     16'd5,     16'd4,
        16'd4,     16'd3,
        16'd3,     16'd2,     16'd2,     16'd2,     16'd2,     16'd1,
        16'd1,     16'd1,     16'd1,     16'd1,     16'd1
    };

    typedef struct packed {
        logic signed [17:0] mixer_adjust;
        logic               mixer_adjust_valid;
        logic signed [7:0]  peak_db;
        logic               clear_held_frame;
        logic               hold_this_frame;
        logic               send_this_frame;
        logic               send_held_frame;
        logic               frame_end;
        logic signed [15:0] scaled_sample;
    } t_result;

    typedef struct packed {
        logic signed [16:0] level_error;
        logic [15:0]        target;
        logic [15:0]        peak;
        logic [15:0]        rate;
        logic [15:0]        gain;
    } t_agc_in;

    typedef struct packed {
        logic signed [16:0] level_error;
        logic signed [17:0] adjust;
        logic [15:0]        gain;
    } t_agc_out;

    // thresholds fall monotonically, so the deepest step met is the count
    function automatic logic signed [7:0] peak_to_db(input logic [15:0] p);
        logic [6:0] n;
        logic [7:0] d;
        n = '0;
        for (int k = 0; k <= DB_STEPS; k++) begin
            if (p <= DB_THR[k]) begin
                n = 7'(k);
            end
        end
        d = {1'b0, n};
        if (p == 16'd0) begin
            return DB_SILENCE;
        end
        return $signed(8'd0 - d);
    endfunction

endpackage

>>> rtl/vga_agc.sv
// AGC step: level error update, gain adjustment and gain saturation.
module vga_agc import vga_pkg::*; (
    input  t_agc_in  i_agc,
    output t_agc_out o_agc
);

    logic [16:0]        w_tgt;
    logic signed [17:0] w_sum;
    logic signed [16:0] w_err;
    logic signed [33:0] w_prod;
    logic signed [33:0] w_round;
    logic signed [17:0] w_adj;
    logic signed [18:0] w_gain_sum;

    assign w_tgt = ({1'b0, i_agc.target} > FULL_SCALE) ? FULL_SCALE : {1'b0, i_agc.target};

    assign w_sum = $signed({i_agc.level_error[16], i_agc.level_error})
                 + $signed({1'b0, w_tgt})
                 - $signed({2'b00, i_agc.peak});
    assign w_err = w_sum[17:1];

    assign w_prod  = w_err * $signed({1'b0, i_agc.rate});
    assign w_round = w_prod + 34'sd16384;
    assign w_adj   = w_round[32:15];

    assign w_gain_sum = $signed({3'b000, i_agc.gain}) + $signed({w_adj[17], w_adj});

    always_comb begin
        o_agc.level_error = w_err;
        o_agc.adjust      = w_adj;
        if (w_gain_sum < 19'sd0) begin
            o_agc.gain = 16'd0;
        end else if (w_gain_sum > 19'sd65535) begin
            o_agc.gain = 16'hFFFF;
        end else begin
            o_agc.gain = w_gain_sum[15:0];
        end
    end

endmodule

>>> rtl/voice_gate_with_agc_unit.sv
// Voice gate with hangover and AGC: top level.
// Path: an accepted input word goes to the input register, then its result
// word to the result register.
// Throughput: one word per cycle unless the output stalls; all state
// (gain, peak, gate, hangover) updates when the result register loads.
// Reset: synchronous, active low; clears valids, gate state and registers
// to their defaults (unity gain, frame length 320).
module voice_gate_with_agc_unit import vga_pkg::*; #(
    parameter int MAX_FRAME = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // sample_in
    input  logic [1:0]  i_s_axis_tuser,   // func
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // scaled_sample[15:0], frame_end, send_held_frame, send_this_frame,
    // hold_this_frame, clear_held_frame, peak_db[7:0], mixer_adjust_valid,
    // mixer_adjust[17:0]
    output logic [47:0] o_m_axis_tdata
);

    localparam int FW = $clog2(MAX_FRAME);
    localparam int LW = ($clog2(MAX_FRAME + 1) > CFG_LEN_W) ? $clog2(MAX_FRAME + 1) : CFG_LEN_W;

    // configuration
    logic [CFG_LEN_W-1:0] r_frame_length;
    logic [15:0]          r_speech_threshold;
    logic [7:0]           r_hold_ticks;
    logic                 r_soft_agc_on;
    logic                 r_hard_agc_on;
    logic [15:0]          r_agc_target;
    logic [15:0]          r_agc_rate;

    // state
    t_gate_mode         r_mode, n_mode;
    logic [7:0]         r_hang, n_hang;
    logic [FW-1:0]      r_fill, n_fill;
    logic [15:0]        r_peak, n_peak;
    logic [15:0]        r_gain, n_gain;
    logic signed [16:0] r_err, n_err;

    // input and result registers
    logic               r_in_valid;
    t_func              r_in_func;
    logic signed [15:0] r_in_sample;
    logic               r_out_valid;
    t_result            r_out;
    t_result            w_res;

    logic w_adv;
    logic w_s_acc;

    assign w_adv           = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_adv;
    assign w_s_acc         = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;

    // sample scaling
    logic signed [32:0] w_prod;
    logic signed [32:0] w_round;
    logic signed [32:0] w_shift;
    logic signed [15:0] w_scaled;
    logic [15:0]        w_mag;
    logic [15:0]        w_peak_smp;

    assign w_prod  = r_in_sample * $signed({1'b0, r_gain});
    assign w_round = w_prod + 33'sd2048;
    assign w_shift = w_round >>> 12;

    always_comb begin
        if (w_shift > 33'sd32767) begin
            w_scaled = 16'sh7FFF;
        end else if (w_shift < -33'sd32768) begin
            w_scaled = 16'sh8000;
        end else begin
            w_scaled = w_shift[15:0];
        end
    end

    assign w_mag      = w_scaled[15] ? (~w_scaled + 16'd1) : w_scaled;
    assign w_peak_smp = (w_mag > r_peak) ? w_mag : r_peak;

    // frame counting
    logic [LW-1:0] w_len_cfg;
    logic [LW-1:0] w_len;
    logic [LW-1:0] w_fill_inc;
    logic          w_frame_done;

    assign w_len_cfg = LW'(r_frame_length);
    assign w_len = (r_frame_length == '0) ? LW'(1) :
                   (w_len_cfg > LW'(MAX_FRAME)) ? LW'(MAX_FRAME) : w_len_cfg;
    assign w_fill_inc   = LW'(r_fill) + LW'(1);
    assign w_frame_done = (w_fill_inc >= w_len);

    // gate decision at frame end
    logic       w_speech;
    t_gate_mode w_mode_start;
    logic [7:0] w_hang_frame;
    logic       w_run_expire;
    logic       w_send_this;
    logic       w_hold_this;
    t_gate_mode w_mode_frame;

    assign w_speech     = (w_peak_smp >= r_speech_threshold);
    assign w_mode_start = (w_speech && r_mode == GATE_WAITING) ? GATE_RUNNING : r_mode;
    assign w_hang_frame = w_speech ? r_hold_ticks : r_hang;
    assign w_run_expire = (w_mode_start == GATE_RUNNING) && (w_hang_frame == 8'd0);
    assign w_send_this  = (w_mode_start == GATE_RUNNING) && (w_hang_frame != 8'd0);
    assign w_hold_this  = w_run_expire || (w_mode_start == GATE_WAITING);
    assign w_mode_frame = w_run_expire ? GATE_WAITING : w_mode_start;

    // AGC
    t_agc_in  w_agc_in;
    t_agc_out w_agc_out;
    logic     w_agc_en;

    assign w_agc_in.level_error = r_err;
    assign w_agc_in.target      = r_agc_target;
    assign w_agc_in.peak        = r_peak;
    assign w_agc_in.rate        = r_agc_rate;
    assign w_agc_in.gain        = r_gain;
    assign w_agc_en = (r_mode == GATE_RUNNING) && (r_soft_agc_on || r_hard_agc_on);

    vga_agc u_agc (
        .i_agc (w_agc_in),
        .o_agc (w_agc_out)
    );

    // next state
    always_comb begin
        n_mode = r_mode;
        n_hang = r_hang;
        n_fill = r_fill;
        n_peak = r_peak;
        n_gain = r_gain;
        n_err  = r_err;
        unique case (r_in_func)
            FUNC_SAMPLE: begin
                n_peak = w_peak_smp;
                if (w_frame_done) begin
                    n_fill = '0;
                    n_hang = w_hang_frame;
                    n_mode = w_mode_frame;
                end else begin
                    n_fill = FW'(w_fill_inc);
                end
            end
            FUNC_TICK: begin
                if (r_hang != 8'd0) begin
                    n_hang = r_hang - 8'd1;
                end
                if (w_agc_en) begin
                    n_err = w_agc_out.level_error;
                    if (r_soft_agc_on) begin
                        n_gain = w_agc_out.gain;
                    end
                end
                n_peak = '0;
            end
            FUNC_START: begin
                if (r_mode != GATE_WAITING && r_mode != GATE_RUNNING) begin
                    n_hang = '0;
                    n_fill = '0;
                    n_mode = GATE_WAITING;
                end
            end
            FUNC_STOP: begin
                n_mode = GATE_STOPPED;
            end
        endcase
    end

    // result word
    always_comb begin
        w_res = '0;
        unique case (r_in_func)
            FUNC_SAMPLE: begin
                w_res.scaled_sample = w_scaled;
                if (w_frame_done) begin
                    w_res.frame_end       = 1'b1;
                    w_res.send_held_frame = w_speech && (r_mode == GATE_WAITING);
                    w_res.send_this_frame = w_send_this;
                    w_res.hold_this_frame = w_hold_this;
                end
            end
            FUNC_TICK: begin
                w_res.peak_db = peak_to_db(r_peak);
                if (w_agc_en && r_hard_agc_on) begin
                    w_res.mixer_adjust_valid = 1'b1;
                    w_res.mixer_adjust       = w_agc_out.adjust;
                end
            end
            FUNC_START: begin
                w_res.clear_held_frame = (r_mode != GATE_WAITING) && (r_mode != GATE_RUNNING);
            end
            FUNC_STOP: begin
                w_res = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_length     <= FRAME_LENGTH_RST;
            r_speech_threshold <= '0;
            r_hold_ticks       <= '0;
            r_soft_agc_on      <= 1'b0;
            r_hard_agc_on      <= 1'b0;
            r_agc_target       <= '0;
            r_agc_rate         <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                CFG_FRAME_LENGTH:     r_frame_length     <= i_cfg_wdata[CFG_LEN_W-1:0];
                CFG_SPEECH_THRESHOLD: r_speech_threshold <= i_cfg_wdata;
                CFG_HOLD_TICKS:       r_hold_ticks       <= i_cfg_wdata[7:0];
                CFG_SOFT_AGC_ON:      r_soft_agc_on      <= i_cfg_wdata[0];
                CFG_HARD_AGC_ON:      r_hard_agc_on      <= i_cfg_wdata[0];
                CFG_AGC_TARGET:       r_agc_target       <= i_cfg_wdata;
                CFG_AGC_RATE:         r_agc_rate         <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= GATE_STOPPED;
            r_hang <= '0;
            r_fill <= '0;
            r_peak <= '0;
            r_gain <= UNITY_GAIN;
            r_err  <= '0;
        end else if (w_adv) begin
            r_mode <= n_mode;
            r_hang <= n_hang;
            r_fill <= n_fill;
            r_peak <= n_peak;
            r_gain <= n_gain;
            r_err  <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_s_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_in_func   <= t_func'(i_s_axis_tuser);
            r_in_sample <= i_s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_res;
        end
    end

endmodule

>>> rtl/vga_checker.sv
// Port-level checks of the voice gate with AGC, bound to the top level.
module vga_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_m_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic [47:0] o_m_axis_tdata
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result word changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // send/hold flags only at frame end, never send_this and hold together
    a_frame_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[17] || o_m_axis_tdata[18] || o_m_axis_tdata[19])
        |-> o_m_axis_tdata[16] && !(o_m_axis_tdata[18] && o_m_axis_tdata[19]))
        else $error("gate flags inconsistent");

    a_db_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ($signed(o_m_axis_tdata[28:21]) <= 8'sd0)
                         && ($signed(o_m_axis_tdata[28:21]) >= -8'sd96))
        else $error("peak level out of range");

endmodule

bind voice_gate_with_agc_unit vga_checker u_vga_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

>>> bench/voice_gate_with_agc_unit_checker.sv
`timescale 1ns / 100ps
// Checker for the voice gate with AGC: tracks config writes, predicts each result word and compares it.
module voice_gate_with_agc_unit_checker import vga_pkg::*; #(
    parameter int MAX_FRAME = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // sample_in
    input  logic [1:0]  i_s_axis_tuser,   // func
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // scaled_sample[15:0], frame_end, send_held_frame, send_this_frame,
    // hold_this_frame, clear_held_frame, peak_db[7:0], mixer_adjust_valid,
    // mixer_adjust[17:0]
    input  logic [47:0] i_m_axis_tdata,
    output int          o_fail_count,
    output int          o_pending
);

    // full scale times 10^(-n/20), floored, for n = 0..19
    localparam int DB_STEP20 [20] = '{
        32768, 29204, 26028, 23197, 20675, 18426, 16422, 14636, 13045, 11626,
        10362, 9235, 8230, 7335, 6538, 5827, 5193, 4628, 4125, 3676
    };

    int frame_len_reg;
    int thr_reg;
    int hold_reg;
    int soft_reg;
    int hard_reg;
    int target_reg;
    int rate_reg;

    t_gate_mode gate;
    int hangover;
    int fill;
    int peak;
    int gain;
    int level_err;

    t_result gate_results_q[$];
    int fail_count = 0;
    int checked_words = 0;

    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] result word %0d: %s is %0d, expected %0d",
                 $time, checked_words, what, got, want);
        fail_count++;
    endtask

    function automatic int peak_in_db(input int p);
        int scale;
        if (p == 0) begin
            return DB_SILENCE;
        end
        for (int n = 90; n > 0; n--) begin
            scale = 1;
            for (int k = 0; k < n / 20; k++) begin
                scale *= 10;
            end
            if (p * scale <= DB_STEP20[n % 20]) begin
                return -n;
            end
        end
        return 0;
    endfunction

    function automatic t_result gate_step(input t_func f, input logic [15:0] word);
        t_result r;
        longint  v;
        longint  adj;
        longint  g;
        int      len;
        int      tgt;
        logic    starting;
        r = '0;
        case (f)
            FUNC_SAMPLE: begin
                v = (longint'($signed(word)) * gain + 2048) >>> 12;
                if (v > 32767) begin
                    v = 32767;
                end else if (v < -32768) begin
                    v = -32768;
                end
                r.scaled_sample = v[15:0];
                if (v < 0) begin
                    v = -v;
                end
                if (int'(v) > peak) begin
                    peak = int'(v);
                end
                len = (frame_len_reg == 0) ? 1 :
                      (frame_len_reg > MAX_FRAME) ? MAX_FRAME : frame_len_reg;
                if (fill + 1 >= len) begin
                    fill = 0;
                    r.frame_end = 1'b1;
                    starting = 1'b0;
                    if (peak >= thr_reg) begin
                        starting = (gate == GATE_WAITING);
                        hangover = hold_reg;
                    end
                    if (starting) begin
                        r.send_held_frame = 1'b1;
                        gate = GATE_RUNNING;
                    end
                    if (gate == GATE_RUNNING) begin
                        if (hangover > 0) begin
                            r.send_this_frame = 1'b1;
                        end else begin
                            gate = GATE_WAITING;
                            r.hold_this_frame = 1'b1;
                        end
                    end else if (gate == GATE_WAITING) begin
                        r.hold_this_frame = 1'b1;
                    end
                end else begin
                    fill++;
                end
            end
            FUNC_TICK: begin
                if (hangover > 0) begin
                    hangover--;
                end
                if (gate == GATE_RUNNING && (soft_reg != 0 || hard_reg != 0)) begin
                    tgt = (target_reg > 32768) ? 32768 : target_reg;
                    level_err = (level_err + tgt - peak) >>> 1;
                    adj = (longint'(level_err) * rate_reg + 16384) >>> 15;
                    if (hard_reg != 0) begin
                        r.mixer_adjust_valid = 1'b1;
                        r.mixer_adjust = adj[17:0];
                    end
                    if (soft_reg != 0) begin
                        g = gain + adj;
                        if (g < 0) begin
                            g = 0;
                        end else if (g > 65535) begin
                            g = 65535;
                        end
                        gain = int'(g);
                    end
                end
                r.peak_db = 8'(peak_in_db(peak));
                peak = 0;
            end
            FUNC_START: begin
                if (gate != GATE_WAITING && gate != GATE_RUNNING) begin
                    hangover = 0;
                    fill = 0;
                    gate = GATE_WAITING;
                    r.clear_held_frame = 1'b1;
                end
            end
            default: begin
                gate = GATE_STOPPED;
            end
        endcase
        return r;
    endfunction

    task automatic compare_word(input t_result got, input t_result want);
        if (got.scaled_sample !== want.scaled_sample)
            report_mismatch("scaled_sample", got.scaled_sample, want.scaled_sample);
        if (got.frame_end !== want.frame_end)
            report_mismatch("frame_end", got.frame_end, want.frame_end);
        if (got.send_held_frame !== want.send_held_frame)
            report_mismatch("send_held_frame", got.send_held_frame, want.send_held_frame);
        if (got.send_this_frame !== want.send_this_frame)
            report_mismatch("send_this_frame", got.send_this_frame, want.send_this_frame);
        if (got.hold_this_frame !== want.hold_this_frame)
            report_mismatch("hold_this_frame", got.hold_this_frame, want.hold_this_frame);
        if (got.clear_held_frame !== want.clear_held_frame)
            report_mismatch("clear_held_frame", got.clear_held_frame, want.clear_held_frame);
        if (got.peak_db !== want.peak_db)
            report_mismatch("peak_db", got.peak_db, want.peak_db);
        if (got.mixer_adjust_valid !== want.mixer_adjust_valid)
            report_mismatch("mixer_adjust_valid", got.mixer_adjust_valid,
                            want.mixer_adjust_valid);
        if (got.mixer_adjust !== want.mixer_adjust)
            report_mismatch("mixer_adjust", got.mixer_adjust, want.mixer_adjust);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_len_reg = FRAME_LENGTH_RST;
            thr_reg = 0;
            hold_reg = 0;
            soft_reg = 0;
            hard_reg = 0;
            target_reg = 0;
            rate_reg = 0;
            gate = GATE_STOPPED;
            hangover = 0;
            fill = 0;
            peak = 0;
            gain = UNITY_GAIN;
            level_err = 0;
            gate_results_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    CFG_FRAME_LENGTH:     frame_len_reg = i_cfg_wdata[CFG_LEN_W-1:0];
                    CFG_SPEECH_THRESHOLD: thr_reg = i_cfg_wdata;
                    CFG_HOLD_TICKS:       hold_reg = i_cfg_wdata[7:0];
                    CFG_SOFT_AGC_ON:      soft_reg = i_cfg_wdata[0];
                    CFG_HARD_AGC_ON:      hard_reg = i_cfg_wdata[0];
                    CFG_AGC_TARGET:       target_reg = i_cfg_wdata;
                    CFG_AGC_RATE:         rate_reg = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (gate_results_q.size() == 0) begin
                    report_mismatch("word with nothing pending, data", i_m_axis_tdata, 0);
                end else begin
                    compare_word(t_result'(i_m_axis_tdata), gate_results_q.pop_front());
                end
                checked_words++;
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                gate_results_q.push_back(gate_step(t_func'(i_s_axis_tuser), i_s_axis_tdata));
            end
        end
        o_pending <= gate_results_q.size();
    end

endmodule

>>> bench/voice_gate_with_agc_unit_tb.sv
`timescale 1ns / 100ps
// Testbench top for the voice gate with AGC: reset, config phases, stimulus and verdict.
module voice_gate_with_agc_unit_tb import vga_pkg::*; ();

    localparam int STALL_LIMIT = 1000;
    localparam int PHASES      = 8;
    localparam int PHASE_WORDS = 250;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_idx = '0;
    logic [15:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic [15:0] s_data = '0;
    logic [1:0]  s_user = '0;
    logic        m_ready = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [47:0] m_data;

    int   mismatches;
    int   pending;
    logic idle_on = 1'b1;
    int   ready_hold = 0;
    int   stall_cycles = 0;

    always #5 i_clk = ~i_clk;

    voice_gate_with_agc_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    voice_gate_with_agc_unit_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_valid),
        .i_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .i_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .i_m_axis_tdata  (m_data),
        .o_fail_count    (mismatches),
        .o_pending       (pending)
    );

    // random receiver backpressure in bursts while idle_on is set
    always @(posedge i_clk) begin
        if (!idle_on) begin
            m_ready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            ready_hold <= $urandom_range(0, 7);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && !((s_valid && s_ready) || (m_valid && m_ready))) begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("FAIL voice_gate_with_agc_unit");
                $finish;
            end
        end else begin
            stall_cycles <= 0;
        end
    end

    task automatic push_word(input t_func f, input logic [15:0] word);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= f;
        s_data  <= word;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int value);
        cfg_wr_en <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= 16'(value);
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input int len, input int thr, input int hold,
                                  input int soft_agc, input int hard_agc, input int target,
                                  input int rate);
        drain_results();
        write_reg(CFG_FRAME_LENGTH, len);
        write_reg(CFG_SPEECH_THRESHOLD, thr);
        write_reg(CFG_HOLD_TICKS, hold);
        write_reg(CFG_SOFT_AGC_ON, soft_agc);
        write_reg(CFG_HARD_AGC_ON, hard_agc);
        write_reg(CFG_AGC_TARGET, target);
        write_reg(CFG_AGC_RATE, rate);
        cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_sample(input int loudness);
        int a;
        case (loudness)
            0:       a = $urandom_range(0, 700);
            1:       a = $urandom_range(0, 32767);
            default: a = $urandom_range(0, 1) ? 32767 : 32768;
        endcase
        if ($urandom_range(0, 1) == 1) begin
            a = -a;
        end
        return 16'(a);
    endfunction

    task automatic run_directed();
        idle_on = 1'b1;
        push_word(FUNC_TICK, 16'h0000);     // silence
        push_word(FUNC_SAMPLE, 16'h7FFF);
        push_word(FUNC_SAMPLE, 16'h8000);   // full-scale peak
        push_word(FUNC_TICK, 16'hFFFF);
        push_word(FUNC_START, 16'h0000);
        push_word(FUNC_START, 16'h0000);    // already started, ignored
        push_word(FUNC_STOP, 16'h0000);
        // zero length acts as one; threshold above full scale never fires
        apply_settings(0, 65535, 255, 1, 1, 65535, 65535);
        push_word(FUNC_START, 16'h0000);
        push_word(FUNC_SAMPLE, 16'h0001);
        push_word(FUNC_SAMPLE, 16'hFFFF);
        push_word(FUNC_TICK, 16'h0000);
        // speech opens the gate, hangover runs out, gate drops back
        apply_settings(4, 1000, 1, 1, 1, 16384, 65535);
        push_word(FUNC_SAMPLE, 16'd5000);
        repeat (3) push_word(FUNC_SAMPLE, 16'h0000);
        push_word(FUNC_TICK, 16'h0000);
        repeat (4) push_word(FUNC_SAMPLE, 16'h0000);
        push_word(FUNC_STOP, 16'h0000);
        // frame length shrinks below the current fill
        apply_settings(8, 1000, 1, 1, 1, 16384, 65535);
        repeat (3) push_word(FUNC_SAMPLE, 16'h0123);
        apply_settings(2, 1000, 1, 1, 1, 16384, 65535);
        push_word(FUNC_SAMPLE, 16'hFEDC);
    endtask

    task automatic run_random_phase(input int ph);
        int len;
        int thr;
        int hold;
        int soft_agc;
        int hard_agc;
        int target;
        int rate;
        int loud;
        int r;
        case (ph)
            1:       len = 1024;
            5:       len = 2047;
            3:       len = 0;
            default: len = ($urandom_range(0, 7) == 0) ? 320 : $urandom_range(1, 12);
        endcase
        case ($urandom_range(0, 5))
            0:       thr = 0;
            1:       thr = 32768;
            2:       thr = 65535;
            default: thr = $urandom_range(0, 12000);
        endcase
        case ($urandom_range(0, 3))
            0:       hold = 0;
            1:       hold = 255;
            default: hold = $urandom_range(1, 6);
        endcase
        soft_agc = (ph == 0) ? 1 : (ph == 3) ? 0 : $urandom_range(0, 1);
        hard_agc = (ph == 0) ? 1 : (ph == 3) ? 0 : $urandom_range(0, 1);
        case ($urandom_range(0, 3))
            0:       target = 0;
            1:       target = 32768;
            2:       target = 65535;
            default: target = $urandom_range(0, 65535);
        endcase
        case ($urandom_range(0, 3))
            0:       rate = 0;
            1:       rate = 65535;
            2:       rate = $urandom_range(0, 4096);
            default: rate = $urandom_range(0, 65535);
        endcase
        apply_settings(len, thr, hold, soft_agc, hard_agc, target, rate);
        idle_on = (ph < PHASES - 1) && ($urandom_range(0, 3) != 0);
        loud = 1;
        push_word(FUNC_START, 16'($urandom));
        for (int n = 0; n < PHASE_WORDS; n++) begin
            if ($urandom_range(0, 15) == 0) begin
                loud = $urandom_range(0, 2);
            end
            r = $urandom_range(0, 99);
            if (r < 4) begin
                push_word(FUNC_START, 16'($urandom));
            end else if (r < 6) begin
                push_word(FUNC_STOP, 16'($urandom));
            end else if (r < 18) begin
                push_word(FUNC_TICK, 16'($urandom));
            end else begin
                push_word(FUNC_SAMPLE, pick_sample(loud));
            end
            if ($urandom_range(0, 199) == 0) begin
                drain_results();
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        for (int ph = 0; ph < PHASES; ph++) begin
            run_random_phase(ph);
        end
        drain_results();
        if (mismatches == 0) begin
            $display("PASS voice_gate_with_agc_unit");
        end else begin
            $display("FAIL voice_gate_with_agc_unit");
        end
        $finish;
    end

endmodule
